// File: hw/rtl/ddft_pkg.sv
// ============================================================================
// ddft_pkg
// Shared types, constants and twiddle-generation functions for the direct DFT.
// ============================================================================
package ddft_pkg;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int TW_W      = 16;
    localparam int PROD_W    = 32;
    localparam int BIN_W     = 24;
    localparam int BIN_IDX_W = 6;
    localparam int RND_SHIFT = 15;

    // Twiddle generation constants (Q28 radians)
    localparam longint unsigned Q28_ONE      = 64'd268435456;
    localparam longint unsigned Q28_PI       = 64'd843314857;
    localparam int              SERIES_TERMS = 24;
    localparam longint unsigned Q15_MAX      = 64'd32767;

    // One step of work handed to the multiply-accumulate unit
    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic [BIN_IDX_W-1:0] bin;
    } ddft_step_t;

    // Status of the accumulators: a finished bin is held
    typedef struct packed {
        logic                 done;
        logic [BIN_IDX_W-1:0] bin;
    } ddft_acc_tag_t;

    // Unsigned shift-and-subtract division, used only to build the tables
    function automatic longint unsigned ddft_udiv(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Taylor series for cos (want_sin = 0) or sin (want_sin = 1), Q28
    function automatic longint ddft_series(input longint unsigned x, input bit want_sin);
        longint unsigned t;
        longint          c;
        longint          s;
        t = x;
        c = longint'(Q28_ONE);
        s = longint'(x);
        for (int j = 2; j < SERIES_TERMS; j++)
        begin
            t = ddft_udiv((t * x) >> 28, 64'(j));
            unique case (j % 4)
                0: c = c + longint'(t);
                1: s = s + longint'(t);
                2: c = c - longint'(t);
                default: s = s - longint'(t);
            endcase
        end
        return want_sin ? s : c;
    endfunction

    // Q28 to Q15 with round half away from zero and saturation at 32767
    function automatic logic signed [TW_W-1:0] ddft_q15(input longint v);
        logic            neg;
        longint unsigned mag;
        longint unsigned r;
        neg = (v < 0);
        mag = neg ? longint'(-v) : longint'(v);
        r   = (mag * Q15_MAX + (Q28_ONE >> 1)) >> 28;
        if (r > Q15_MAX)
        begin
            r = Q15_MAX;
        end
        return neg ? -TW_W'(r) : TW_W'(r);
    endfunction

endpackage

// File: hw/rtl/ddft_cell.sv
// ============================================================================
// ddft_cell
// One slot of the sample ring: holds a sample and takes its neighbor's value
// when the ring shifts.
// ============================================================================
module ddft_cell (
    input  logic                               clk,
    input  logic                               shift_en,
    input  logic signed [ddft_pkg::SAMPLE_W-1:0] d,
    output logic signed [ddft_pkg::SAMPLE_W-1:0] q
);
    import ddft_pkg::*;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;

    // hold or take the neighbor's sample
    always_comb
    begin
        sample_next = shift_en ? d : sample_reg;
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign q = sample_reg;

endmodule

// File: hw/rtl/ddft_mac.sv
// ============================================================================
// ddft_mac
// Complex multiply-accumulate pair: registered products of the head sample
// with cos and sin, then exact accumulation over one bin.
// ============================================================================
module ddft_mac #(
    parameter int ACC_W = 38
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  ddft_pkg::ddft_step_t                 step,
    input  logic signed [ddft_pkg::SAMPLE_W-1:0] x,
    input  logic signed [ddft_pkg::TW_W-1:0]     tw_cos,
    input  logic signed [ddft_pkg::TW_W-1:0]     tw_sin,
    output logic signed [ACC_W-1:0]              acc_re,
    output logic signed [ACC_W-1:0]              acc_im,
    output ddft_pkg::ddft_acc_tag_t              acc_tag
);
    import ddft_pkg::*;

    ddft_step_t                 s1_reg;
    ddft_step_t                 s1_next;
    ddft_acc_tag_t              tag_reg;
    ddft_acc_tag_t              tag_next;
    logic signed [PROD_W-1:0]   prod_re_reg;
    logic signed [PROD_W-1:0]   prod_im_reg;
    logic signed [PROD_W-1:0]   prod_re_next;
    logic signed [PROD_W-1:0]   prod_im_next;
    logic signed [ACC_W-1:0]    acc_re_reg;
    logic signed [ACC_W-1:0]    acc_im_reg;
    logic signed [ACC_W-1:0]    acc_re_next;
    logic signed [ACC_W-1:0]    acc_im_next;

    // multiply stage
    always_comb
    begin
        prod_re_next = PROD_W'(x) * PROD_W'(tw_cos);
        prod_im_next = PROD_W'(x) * PROD_W'(tw_sin);
        s1_next      = step;
    end

    // accumulate stage; imaginary part takes the negated sine products
    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (s1_reg.valid)
        begin
            if (s1_reg.first)
            begin
                acc_re_next = ACC_W'(prod_re_reg);
                acc_im_next = -ACC_W'(prod_im_reg);
            end
            else
            begin
                acc_re_next = acc_re_reg + ACC_W'(prod_re_reg);
                acc_im_next = acc_im_reg - ACC_W'(prod_im_reg);
            end
        end
        tag_next.done = s1_reg.valid & s1_reg.last;
        tag_next.bin  = s1_reg.bin;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            tag_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg  <= s1_next;
            tag_reg <= tag_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
            acc_re_reg  <= acc_re_next;
            acc_im_reg  <= acc_im_next;
        end
    end

    assign acc_re  = acc_re_reg;
    assign acc_im  = acc_im_reg;
    assign acc_tag = tag_reg;

endmodule

// File: hw/rtl/direct_dft_unit.sv
// ============================================================================
// direct_dft_unit
// Direct DFT of a frame of POINTS real samples into POINTS complex bins.
// ============================================================================
// Usage:
//   Sample channel: one signed 16-bit sample per beat, in frame order. Each
//   sample shifts into a ring of POINTS cells at its tail.
//   Bin channel: after the last sample of a frame, POINTS beats carry the
//   bins m = 0..POINTS-1 in order, each with bin_index and last_bin set on
//   the final bin.
//   Output path: after the frame's last sample is accepted, each bin passes
//   the product register, the accumulator and the output register in turn.
//   Compute: the single cos/sin multiply-accumulate pair walks the sample
//   ring once per bin; a frame is fully loaded before its bins are computed,
//   and no new sample is taken until that compute is done.
//   sample_stall is high from the frame's last sample until the last bin
//   has entered the multiply pipeline.
//   Reset clears the sequencer, the load count and the output valid; the
//   sample ring holds nothing defined until a full frame is loaded.
//   A stalled bin beat holds its payload; the whole compute pipeline freezes
//   while a finished bin waits behind it.
// ============================================================================
module direct_dft_unit #(
    parameter int POINTS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [ddft_pkg::SAMPLE_W-1:0] sample,
    output logic                                 bin_valid,
    input  logic                                 bin_stall,
    output logic signed [ddft_pkg::BIN_W-1:0]    bin_real,
    output logic signed [ddft_pkg::BIN_W-1:0]    bin_imag,
    output logic [ddft_pkg::BIN_IDX_W-1:0]       bin_index,
    output logic                                 last_bin
);
    import ddft_pkg::*;

    localparam int IDX_W = $clog2(POINTS);
    localparam int ACC_W = PROD_W + IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(POINTS - 1);
    localparam logic [IDX_W:0]   POINTS_W  = (IDX_W + 1)'(POINTS);
    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (RND_SHIFT - 1);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_CALC = 2'b10
    } ddft_state_t;

    ddft_state_t      state_reg;
    ddft_state_t      state_next;
    logic [IDX_W-1:0] load_cnt_reg;
    logic [IDX_W-1:0] load_cnt_next;
    logic [IDX_W-1:0] n_reg;
    logic [IDX_W-1:0] n_next;
    logic [IDX_W-1:0] m_reg;
    logic [IDX_W-1:0] m_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic [IDX_W:0]   k_sum;
    logic [IDX_W-1:0] k_wrap;

    logic             sample_acc;
    logic             adv;
    logic             ring_shift;
    logic             out_load;

    logic signed [SAMPLE_W-1:0] ring [POINTS];
    logic signed [SAMPLE_W-1:0] ring_in [POINTS];
    logic signed [TW_W-1:0]     rom_cos [POINTS];
    logic signed [TW_W-1:0]     rom_sin [POINTS];

    ddft_step_t               step;
    ddft_acc_tag_t            acc_tag;
    logic signed [ACC_W-1:0]  acc_re;
    logic signed [ACC_W-1:0]  acc_im;
    logic signed [ACC_W-1:0]  sum_re;
    logic signed [ACC_W-1:0]  sum_im;

    logic                     bin_valid_reg;
    logic                     bin_valid_next;
    logic signed [BIN_W-1:0]  bin_real_reg;
    logic signed [BIN_W-1:0]  bin_imag_reg;
    logic signed [BIN_W-1:0]  bin_real_next;
    logic signed [BIN_W-1:0]  bin_imag_next;
    logic [BIN_IDX_W-1:0]     bin_index_reg;
    logic                     last_bin_reg;

    // twiddle tables, built at elaboration from the folded angle
    for (genvar gk = 0; gk < POINTS; gk++)
    begin : g_rom
        localparam bit              FLIP = (2 * gk > POINTS);
        localparam longint unsigned KF   = FLIP ? longint'(POINTS - gk) : longint'(gk);
        localparam longint unsigned ANG  = (64'd2 * Q28_PI * KF) / POINTS;
        localparam logic signed [TW_W-1:0] COS_K = ddft_q15(ddft_series(ANG, 1'b0));
        localparam logic signed [TW_W-1:0] SIN_P = ddft_q15(ddft_series(ANG, 1'b1));
        localparam logic signed [TW_W-1:0] SIN_K = FLIP ? -SIN_P : SIN_P;
        assign rom_cos[gk] = COS_K;
        assign rom_sin[gk] = SIN_K;
    end

    // handshakes and pipeline freeze
    assign sample_stall = (state_reg != ST_LOAD);
    assign sample_acc   = sample_valid & ~sample_stall;
    assign adv          = ~(acc_tag.done & bin_valid_reg & bin_stall);
    assign out_load     = acc_tag.done & (~bin_valid_reg | ~bin_stall);
    assign ring_shift   = sample_acc | ((state_reg == ST_CALC) & adv);

    // sample ring: new samples enter at the tail, compute rotates head to tail
    for (genvar gc = 0; gc < POINTS; gc++)
    begin : g_ring
        if (gc == POINTS - 1)
        begin : g_tail
            assign ring_in[gc] = (state_reg == ST_LOAD) ? sample : ring[0];
        end
        else
        begin : g_body
            assign ring_in[gc] = ring[gc + 1];
        end
        ddft_cell u_cell (
            .clk      (clk),
            .shift_en (ring_shift),
            .d        (ring_in[gc]),
            .q        (ring[gc])
        );
    end

    // twiddle phase: (n*m) mod POINTS built up one step at a time
    always_comb
    begin
        k_sum  = {1'b0, k_reg} + {1'b0, m_reg};
        k_wrap = (k_sum >= POINTS_W) ? IDX_W'(k_sum - POINTS_W) : IDX_W'(k_sum);
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        n_next        = n_reg;
        m_next        = m_reg;
        k_next        = k_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (sample_acc)
                begin
                    if (load_cnt_reg == LAST_IDX)
                    begin
                        load_cnt_next = '0;
                        state_next    = ST_CALC;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + IDX_W'(1);
                    end
                end
            end
            ST_CALC:
            begin
                if (adv)
                begin
                    if (n_reg == LAST_IDX)
                    begin
                        n_next = '0;
                        k_next = '0;
                        if (m_reg == LAST_IDX)
                        begin
                            m_next     = '0;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            m_next = m_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        n_next = n_reg + IDX_W'(1);
                        k_next = k_wrap;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            n_reg        <= '0;
            m_reg        <= '0;
            k_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            n_reg        <= n_next;
            m_reg        <= m_next;
            k_reg        <= k_next;
        end
    end

    // step handed to the MAC pair
    always_comb
    begin
        step.valid = (state_reg == ST_CALC);
        step.first = (n_reg == '0);
        step.last  = (n_reg == LAST_IDX);
        step.bin   = BIN_IDX_W'(m_reg);
    end

    ddft_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .step    (step),
        .x       (ring[0]),
        .tw_cos  (rom_cos[k_reg]),
        .tw_sin  (rom_sin[k_reg]),
        .acc_re  (acc_re),
        .acc_im  (acc_im),
        .acc_tag (acc_tag)
    );

    // round half up, then drop 15 fraction bits
    always_comb
    begin
        sum_re        = acc_re + RND_BIAS;
        sum_im        = acc_im + RND_BIAS;
        bin_real_next = BIN_W'(sum_re >>> RND_SHIFT);
        bin_imag_next = BIN_W'(sum_im >>> RND_SHIFT);
    end

    // output register
    always_comb
    begin
        priority if (out_load)
        begin
            bin_valid_next = 1'b1;
        end
        else if (!bin_stall)
        begin
            bin_valid_next = 1'b0;
        end
        else
        begin
            bin_valid_next = bin_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= 1'b0;
        end
        else
        begin
            bin_valid_reg <= bin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            bin_real_reg  <= bin_real_next;
            bin_imag_reg  <= bin_imag_next;
            bin_index_reg <= acc_tag.bin;
            last_bin_reg  <= (acc_tag.bin == BIN_IDX_W'(POINTS - 1));
        end
    end

    assign bin_valid = bin_valid_reg;
    assign bin_real  = bin_real_reg;
    assign bin_imag  = bin_imag_reg;
    assign bin_index = bin_index_reg;
    assign last_bin  = last_bin_reg;

`ifndef ASSERT_OFF
    // no sample is half counted while bins are being computed
    a_calc_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> (load_cnt_reg == '0))
        else $error("load count not cleared during compute");

    // phase restarts at zero with every bin
    a_phase_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) && (n_reg == '0) |-> (k_reg == '0))
        else $error("twiddle phase not zero at start of bin");

    // frame end starts compute at bin zero
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        sample_acc && (load_cnt_reg == LAST_IDX)
        |=> (state_reg == ST_CALC) && (m_reg == '0) && (n_reg == '0))
        else $error("compute did not start at bin zero");

    // a finished bin waiting on a blocked output is not lost
    a_done_held: assert property (@(posedge clk) disable iff (!rst_n)
        acc_tag.done && bin_valid && bin_stall |=> acc_tag.done && $stable(acc_tag.bin))
        else $error("finished bin dropped while output stalled");

    // a stalled bin beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid && bin_stall
        |=> bin_valid && $stable({bin_real, bin_imag, bin_index, last_bin}))
        else $error("bin beat changed while stalled");
`endif

endmodule

// File: tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for direct_dft_unit. Frames of real samples go in with
// random gaps, and the unit's bins come out under random back-pressure. Every
// accepted sample also feeds a bit-exact DFT of the frame built from the same
// Q1.15 twiddle ROM. Each bin beat is checked in order against that result.
// ============================================================================
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ddft_pkg::*;

    localparam int POINTS      = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOW_ERRORS = 10;

    // Q28 angle and series constants for the twiddle ROM
    localparam longint unsigned ANG_ONE   = 64'd268435456;
    localparam longint unsigned ANG_PI    = 64'd843314857;
    localparam int              N_TERMS   = 24;
    localparam longint unsigned FULL_Q15  = 64'd32767;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        bit                         drain;  // hold off until all bins are out
    } sample_beat_t;

    typedef struct {
        logic signed [BIN_W-1:0]     re;
        logic signed [BIN_W-1:0]     im;
        logic [BIN_IDX_W-1:0]        idx;
        logic                        last;
    } bin_beat_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        sample_valid = 1'b0;
    logic                        sample_stall;
    logic signed [SAMPLE_W-1:0]  sample       = '0;
    logic                        bin_valid;
    logic                        bin_stall    = 1'b0;
    logic signed [BIN_W-1:0]     bin_real;
    logic signed [BIN_W-1:0]     bin_imag;
    logic [BIN_IDX_W-1:0]        bin_index;
    logic                        last_bin;

    // Predictor state
    int                          cos_rom [POINTS];
    int                          sin_rom [POINTS];
    logic signed [SAMPLE_W-1:0]  frame_buf [POINTS];
    int                          load_slot = 0;

    sample_beat_t                sample_q[$];
    bin_beat_t                   bins_due[$];

    int                          err_count   = 0;
    int                          cycle_count = 0;

    // Driver and monitor bookkeeping
    bit                          calm      = 1'b0;
    int                          calm_left = 0;
    int                          idle_cycles;
    int                          gap_need;
    bit                          take_beat;
    sample_beat_t                next_beat;
    int                          hold_left = 0;
    bin_beat_t                   want;

    direct_dft_unit #(
        .POINTS(POINTS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .bin_valid    (bin_valid),
        .bin_stall    (bin_stall),
        .bin_real     (bin_real),
        .bin_imag     (bin_imag),
        .bin_index    (bin_index),
        .last_bin     (last_bin)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Q28 magnitude to Q15, round half away from zero, saturate at +32767
    function automatic int to_q15(input longint v);
        bit              neg;
        longint unsigned mag;
        longint unsigned r;
        neg = (v < 0);
        mag = neg ? longint'(-v) : longint'(v);
        r   = (mag * FULL_Q15 + (ANG_ONE >> 1)) >> 28;
        if (r > FULL_Q15)
        begin
            r = FULL_Q15;
        end
        return neg ? -int'(r) : int'(r);
    endfunction

    // Cos/sin ROM: fold angle into [0, pi], Taylor series in Q28
    task automatic build_twiddle_rom();
        int              kk;
        bit              flip;
        longint unsigned x;
        longint unsigned t;
        longint          c;
        longint          s;
        for (int k = 0; k < POINTS; k++)
        begin
            kk   = k;
            flip = 1'b0;
            if (2 * kk > POINTS)
            begin
                kk   = POINTS - kk;
                flip = 1'b1;
            end
            x = (2 * ANG_PI * longint'(kk)) / longint'(POINTS);
            t = x;
            c = longint'(ANG_ONE);
            s = longint'(x);
            for (int j = 2; j < N_TERMS; j++)
            begin
                t = ((t * x) >> 28) / longint'(j);
                case (j % 4)
                    0: c = c + longint'(t);
                    1: s = s + longint'(t);
                    2: c = c - longint'(t);
                    default: s = s - longint'(t);
                endcase
            end
            cos_rom[k] = to_q15(c);
            sin_rom[k] = flip ? -to_q15(s) : to_q15(s);
        end
    endtask

    // Store one sample; on the frame's last slot compute all bins exactly
    task automatic accept_sample(input logic signed [SAMPLE_W-1:0] x);
        longint    re_acc;
        longint    im_acc;
        int        k;
        bin_beat_t b;
        frame_buf[load_slot] = x;
        if (load_slot != POINTS - 1)
        begin
            load_slot++;
            return;
        end
        load_slot = 0;
        for (int m = 0; m < POINTS; m++)
        begin
            re_acc = 0;
            im_acc = 0;
            for (int n = 0; n < POINTS; n++)
            begin
                k      = (n * m) % POINTS;
                re_acc = re_acc + longint'(frame_buf[n]) * longint'(cos_rom[k]);
                im_acc = im_acc - longint'(frame_buf[n]) * longint'(sin_rom[k]);
            end
            // round half up, then drop 15 fraction bits
            b.re   = BIN_W'((re_acc + 64'sd16384) >>> 15);
            b.im   = BIN_W'((im_acc + 64'sd16384) >>> 15);
            b.idx  = BIN_IDX_W'(m);
            b.last = (m == POINTS - 1);
            bins_due = {bins_due, b};
        end
    endtask

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] v, input bit drain);
        sample_beat_t it;
        it.value = v;
        it.drain = drain;
        sample_q = {sample_q, it};
    endtask

    // Alternate busy stretches with stretches of no idling
    always @(posedge clk)
    begin
        if (calm_left == 0)
        begin
            calm      <= ($urandom_range(0, 2) == 0);
            calm_left <= $urandom_range(20, 300);
        end
        else
        begin
            calm_left <= calm_left - 1;
        end
    end

    // Sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            idle_cycles  = 0;
            gap_need     = 0;
        end
        else
        begin
            take_beat = sample_valid && !sample_stall;
            if (take_beat)
            begin
                accept_sample(sample);
                idle_cycles = 0;
                gap_need    = draw_wait();
            end
            if (!sample_valid || take_beat)
            begin
                if (sample_q.size() > 0 && idle_cycles >= gap_need
                    && !(sample_q[0].drain && bins_due.size() > 0))
                begin
                    next_beat = sample_q.pop_front();
                    sample_valid <= 1'b1;
                    sample       <= next_beat.value;
                end
                else
                begin
                    sample_valid <= 1'b0;
                    idle_cycles  = idle_cycles + 1;
                end
            end
        end
    end

    // Bin monitor and random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (bin_valid && !bin_stall)
            begin
                if (bins_due.size() == 0)
                begin
                    if (err_count < SHOW_ERRORS)
                    begin
                        $display("ERROR: unexpected bin beat re=%0d im=%0d idx=%0d last=%0b",
                                 bin_real, bin_imag, bin_index, last_bin);
                    end
                    err_count++;
                end
                else
                begin
                    want = bins_due.pop_front();
                    if (bin_real !== want.re || bin_imag !== want.im
                        || bin_index !== want.idx || last_bin !== want.last)
                    begin
                        if (err_count < SHOW_ERRORS)
                        begin
                            $display("ERROR: bin %0d exp re=%0d im=%0d idx=%0d last=%0b",
                                     want.idx, want.re, want.im, want.idx, want.last);
                            $display("       got re=%0d im=%0d idx=%0d last=%0b",
                                     bin_real, bin_imag, bin_index, last_bin);
                        end
                        err_count++;
                    end
                end
                hold_left = draw_wait();
            end
            else if (hold_left > 0)
            begin
                hold_left--;
            end
            bin_stall <= (hold_left > 0);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic signed [SAMPLE_W-1:0] corner_vals [18];
        logic signed [SAMPLE_W-1:0] v;
        bit                         neg_frame;

        corner_vals = '{16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd1, -16'sd2,
                        16'sd21845, -16'sd21846, 16'sd16384, -16'sd16384,
                        16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
                        16'sd255, -16'sd256, 16'sd12345, -16'sd12345};

        build_twiddle_rom();

        // Frame 0: corner values up front, full-range random after
        foreach (corner_vals[i])
        begin
            push_sample(corner_vals[i], 1'b0);
        end
        for (int i = 0; i < POINTS - 18; i++)
        begin
            push_sample(SAMPLE_W'($urandom), 1'b0);
        end

        // Frame 1: near full-scale DC, mostly one extreme; sent after a full drain
        neg_frame = $urandom_range(0, 1);
        for (int i = 0; i < POINTS; i++)
        begin
            v = ((neg_frame ^ ($urandom_range(0, 7) == 0)) != 0) ? -16'sd32768 : 16'sd32767;
            push_sample(v, i == 0);
        end

        // Frame 2: mix of small values and full-range values
        for (int i = 0; i < POINTS; i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                v = SAMPLE_W'($urandom_range(0, 511)) - 16'sd256;
            end
            else
            begin
                v = SAMPLE_W'($urandom);
            end
            push_sample(v, 1'b0);
        end

        // Partial frame: stored, produces no bins
        for (int i = 0; i < 12; i++)
        begin
            push_sample(SAMPLE_W'($urandom), 1'b0);
        end

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (sample_q.size() > 0 || sample_valid)
        begin
            @(posedge clk);
        end
        while (bins_due.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (POINTS * POINTS + POINTS + 16) @(posedge clk);

        if (err_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
